// ----- src/stkc_pkg.sv -----
// Shared types, widths and codes for the stack calculator.
`default_nettype none

package stkc_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int DATA_W          = 32;
    localparam int ACT_W           = 3;
    localparam int IDX_W           = 10;
    localparam int ERR_W           = 3;
    localparam int CNT_OUT_W       = 11;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH        = 3'd0,
        ACT_POP         = 3'd1,
        ACT_PEEK_TOP    = 3'd2,
        ACT_PEEK_BOTTOM = 3'd3,
        ACT_ADD         = 3'd4,
        ACT_SUB         = 3'd5,
        ACT_MUL         = 3'd6,
        ACT_DIV         = 3'd7
    } t_action;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK      = 3'd0,
        ERR_EMPTY   = 3'd1,
        ERR_RANGE   = 3'd2,
        ERR_FEW     = 3'd3,
        ERR_DIVZERO = 3'd4,
        ERR_FULL    = 3'd5
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_TOP,
        S_LEFT,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- src/stkc_mem.sv -----
// Stack storage: one write port and one read port with registered read data.
`default_nettype none

module stkc_mem
    import stkc_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_store [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_store[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- src/stkc_div.sv -----
// Iterative signed floor divider, one quotient bit per cycle.
`default_nettype none

module stkc_div
    import stkc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_dmag;
    logic              r_neg;

    logic [DATA_W-1:0] left_mag;
    logic [DATA_W-1:0] right_mag;
    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] diff;

    assign left_mag  = i_left[DATA_W-1]  ? (~i_left + 1'b1)  : i_left;
    assign right_mag = i_right[DATA_W-1] ? (~i_right + 1'b1) : i_right;
    assign shifted   = {r_rem[DATA_W-1:0], r_quo[DATA_W-1]};
    assign diff      = {1'b0, shifted} - {2'b00, r_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= left_mag;
            r_rem  <= '0;
            r_dmag <= right_mag;
            r_neg  <= i_left[DATA_W-1] ^ i_right[DATA_W-1];
        end else if (r_busy) begin
            if (!diff[DATA_W+1]) begin
                r_rem <= diff[DATA_W:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    // A negative quotient with a nonzero remainder rounds one further down.
    assign o_quotient = !r_neg   ? r_quo :
                        (|r_rem) ? ~r_quo : (~r_quo + 1'b1);
    assign o_done     = r_done;

endmodule

`default_nettype wire

// ----- src/stack_calculator_core.sv -----
// Top level of the stack calculator: sequencer, count register and result register.
//
//   Channel  Direction  Handshake                  Word
//   in       input      i_in_valid / o_in_stall    action, push_value, peek_index
//   out      output     o_out_valid / i_out_stall  result_value, error_code, entry_count
//
// One word is processed at a time. A push, or an error found at decode, goes from decode
// straight to done; a pop or peek passes through top; add, subtract, multiply and divide by
// zero pass through top, left and exec; divide also waits in div for the divider.
// The next word is taken once the result has been loaded and the sequencer is back in idle.
// Reset is synchronous and empties the stack; the storage itself is not cleared.
// While a result is stalled, the next word is still taken and processed, and its result
// waits in the sequencer until the output register frees; only then is another word taken.
`default_nettype none

module stack_calculator_core
    import stkc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ACT_W-1:0]            i_action,
    input  logic signed [DATA_W-1:0]    i_push_value,
    input  logic [IDX_W-1:0]            i_peek_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [DATA_W-1:0]    o_result_value,
    output logic [ERR_W-1:0]            o_error_code,
    output logic [CNT_OUT_W-1:0]        o_entry_count
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    t_action           r_action;
    logic [DATA_W-1:0] r_value;
    logic [IDX_W-1:0]  r_index;
    logic [DATA_W-1:0] r_res;
    logic [DATA_W-1:0] n_res;
    t_err              r_err;
    t_err              n_err;
    logic [DATA_W-1:0] r_right;
    logic [DATA_W-1:0] n_right;
    logic [DATA_W-1:0] r_left;
    logic [DATA_W-1:0] n_left;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    t_err              r_out_err;
    logic [CW-1:0]     r_out_count;

    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [DATA_W-1:0] mem_rd_data;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quotient;
    logic              in_stall;
    logic              out_load;

    logic [CW-1:0]          count_m1;
    logic [CW-1:0]          count_m2;
    logic [CW+IDX_W-1:0]    idx_ext;
    logic [CW+IDX_W-1:0]    cnt_ext;
    logic [CW+CNT_OUT_W-1:0] out_cnt_ext;
    logic                   is_full;
    logic                   is_empty;
    logic                   is_few;
    logic                   idx_bad;
    logic [CW-1:0]          peek_top_addr;
    logic [DATA_W-1:0]      product;

    assign count_m1      = r_count - CW'(1);
    assign count_m2      = r_count - CW'(2);
    assign idx_ext       = {{CW{1'b0}}, r_index};
    assign cnt_ext       = {{IDX_W{1'b0}}, r_count};
    assign is_full       = (r_count == CW'(STACK_DEPTH));
    assign is_empty      = (r_count == '0);
    assign is_few        = (r_count < CW'(2));
    assign idx_bad       = (idx_ext >= cnt_ext);
    assign peek_top_addr = count_m1 - idx_ext[CW-1:0];
    assign product       = r_left * r_right;

    stkc_mem #(
        .DEPTH(STACK_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    stkc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_left     (r_left),
        .i_right    (r_right),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    always_comb begin
        n_count     = r_count;
        n_res       = r_res;
        n_err       = r_err;
        n_right     = r_right;
        n_left      = r_left;
        mem_wr_en   = 1'b0;
        mem_wr_addr = count_m2[AW-1:0];
        mem_wr_data = r_res;
        mem_rd_en   = 1'b0;
        mem_rd_addr = count_m1[AW-1:0];
        div_start   = 1'b0;
        in_stall    = 1'b1;
        out_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_stall = 1'b0;
            end
            S_DECODE: begin
                n_res = '0;
                n_err = ERR_OK;
                case (r_action)
                    ACT_PUSH: begin
                        if (is_full) begin
                            n_err = ERR_FULL;
                        end else begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = r_count[AW-1:0];
                            mem_wr_data = r_value;
                            n_count     = r_count + CW'(1);
                        end
                    end
                    ACT_POP: begin
                        if (is_empty) begin
                            n_err = ERR_EMPTY;
                        end else begin
                            mem_rd_en = 1'b1;
                        end
                    end
                    ACT_PEEK_TOP: begin
                        if (idx_bad) begin
                            n_err = ERR_RANGE;
                        end else begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = peek_top_addr[AW-1:0];
                        end
                    end
                    ACT_PEEK_BOTTOM: begin
                        if (idx_bad) begin
                            n_err = ERR_RANGE;
                        end else begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = idx_ext[AW-1:0];
                        end
                    end
                    default: begin
                        if (is_few) begin
                            n_err = ERR_FEW;
                        end else begin
                            mem_rd_en = 1'b1;
                        end
                    end
                endcase
            end
            S_TOP: begin
                case (r_action)
                    ACT_POP: begin
                        n_res   = mem_rd_data;
                        n_count = count_m1;
                    end
                    ACT_PUSH, ACT_PEEK_TOP, ACT_PEEK_BOTTOM: begin
                        n_res = mem_rd_data;
                    end
                    default: begin
                        n_right     = mem_rd_data;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = count_m2[AW-1:0];
                    end
                endcase
            end
            S_LEFT: begin
                n_left = mem_rd_data;
            end
            S_EXEC: begin
                case (r_action)
                    ACT_DIV: begin
                        if (r_right == '0) begin
                            n_err   = ERR_DIVZERO;
                            n_count = count_m2;
                        end else begin
                            div_start = 1'b1;
                        end
                    end
                    default: begin
                        case (r_action)
                            ACT_ADD: n_res = r_left + r_right;
                            ACT_SUB: n_res = r_left - r_right;
                            default: n_res = product;
                        endcase
                        mem_wr_en   = 1'b1;
                        mem_wr_data = n_res;
                        n_count     = count_m1;
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_res       = div_quotient;
                    mem_wr_en   = 1'b1;
                    mem_wr_data = div_quotient;
                    n_count     = count_m1;
                end
            end
            S_DONE: begin
                out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = mem_rd_en ? S_TOP : S_DONE;
            end
            S_TOP: begin
                n_state = mem_rd_en ? S_LEFT : S_DONE;
            end
            S_LEFT: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = div_start ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_err   <= n_err;
        r_right <= n_right;
        r_left  <= n_left;
        if (i_in_valid && !in_stall) begin
            r_action <= t_action'(i_action);
            r_value  <= i_push_value;
            r_index  <= i_peek_index;
        end
        if (out_load) begin
            r_out_value <= r_res;
            r_out_err   <= r_err;
            r_out_count <= r_count;
        end
    end

    assign out_cnt_ext    = {{CNT_OUT_W{1'b0}}, r_out_count};
    assign o_in_stall     = in_stall;
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_error_code   = r_out_err;
    assign o_entry_count  = out_cnt_ext[CNT_OUT_W-1:0];

endmodule

`default_nettype wire

// ----- dv/stack_calculator_checker.sv -----
// Checker for the stack calculator: predicts each result word and compares what comes out.
`timescale 1ns / 100ps

module stack_calculator_checker
    import stkc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [ACT_W-1:0]            i_action,
    input  logic signed [DATA_W-1:0]    i_push_value,
    input  logic [IDX_W-1:0]            i_peek_index,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic signed [DATA_W-1:0]    i_result_value,
    input  logic [ERR_W-1:0]            i_error_code,
    input  logic [CNT_OUT_W-1:0]        i_entry_count,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_stack_level,
    output int                          o_peak_level,
    output int                          o_result_count,
    output logic [5:0]                  o_codes_seen
);

    typedef struct {
        logic signed [DATA_W-1:0] value;
        t_err                     code;
        logic [CNT_OUT_W-1:0]     count;
    } t_calc_result;

    logic signed [DATA_W-1:0] shadow_stack [STACK_DEPTH];
    int unsigned              shadow_level = 0;
    t_calc_result             results_due [$];
    int                       fail_n = 0;
    int                       peak_n = 0;
    int                       seen_n = 0;
    logic [5:0]               codes_n = '0;

    function automatic logic signed [DATA_W-1:0] floor_quotient(
        input logic signed [DATA_W-1:0] num,
        input logic signed [DATA_W-1:0] den
    );
        longint n, d, q, rem;
        n = num;
        d = den;
        q = n / d;
        rem = n % d;
        if (rem != 0 && ((rem < 0) != (d < 0))) begin
            q = q - 1;
        end
        return q[DATA_W-1:0];
    endfunction

    function automatic t_calc_result calc_step(
        input t_action                  act,
        input logic signed [DATA_W-1:0] val,
        input logic [IDX_W-1:0]         idx
    );
        t_calc_result             r;
        logic signed [DATA_W-1:0] lhs, rhs;
        r.value = '0;
        r.code  = ERR_OK;
        case (act)
            ACT_PUSH: begin
                if (shadow_level >= STACK_DEPTH) begin
                    r.code = ERR_FULL;
                end else begin
                    shadow_stack[shadow_level] = val;
                    shadow_level++;
                end
            end
            ACT_POP: begin
                if (shadow_level == 0) begin
                    r.code = ERR_EMPTY;
                end else begin
                    shadow_level--;
                    r.value = shadow_stack[shadow_level];
                end
            end
            ACT_PEEK_TOP: begin
                if (idx >= shadow_level) begin
                    r.code = ERR_RANGE;
                end else begin
                    r.value = shadow_stack[shadow_level - 1 - idx];
                end
            end
            ACT_PEEK_BOTTOM: begin
                if (idx >= shadow_level) begin
                    r.code = ERR_RANGE;
                end else begin
                    r.value = shadow_stack[idx];
                end
            end
            default: begin
                if (shadow_level < 2) begin
                    r.code = ERR_FEW;
                end else begin
                    rhs = shadow_stack[shadow_level - 1];
                    lhs = shadow_stack[shadow_level - 2];
                    shadow_level -= 2;
                    if (act == ACT_DIV && rhs == 0) begin
                        r.code = ERR_DIVZERO;
                    end else begin
                        case (act)
                            ACT_ADD: r.value = lhs + rhs;
                            ACT_SUB: r.value = lhs - rhs;
                            ACT_MUL: r.value = lhs * rhs;
                            default: r.value = floor_quotient(lhs, rhs);
                        endcase
                        shadow_stack[shadow_level] = r.value;
                        shadow_level++;
                    end
                end
            end
        endcase
        r.count = CNT_OUT_W'(shadow_level);
        return r;
    endfunction

    task automatic report_field(input string field, input longint want_v, input longint got_v);
        fail_n++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : watch
        t_calc_result want;
        if (!i_rst_n) begin
            shadow_level = 0;
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    fail_n++;
                    $display("%0t: result word with none expected, got value %0d code %0d count %0d",
                             $time, i_result_value, i_error_code, i_entry_count);
                end else begin
                    want = results_due.pop_front();
                    seen_n++;
                    codes_n[want.code] = 1'b1;
                    if (i_result_value !== want.value) begin
                        report_field("result_value", want.value, i_result_value);
                    end
                    if (i_error_code !== want.code) begin
                        report_field("error_code", want.code, i_error_code);
                    end
                    if (i_entry_count !== want.count) begin
                        report_field("entry_count", want.count, i_entry_count);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                results_due.push_back(calc_step(t_action'(i_action), i_push_value, i_peek_index));
                if (shadow_level > peak_n) begin
                    peak_n = shadow_level;
                end
            end
        end
        o_fail_count   <= fail_n;
        o_pending      <= results_due.size();
        o_stack_level  <= shadow_level;
        o_peak_level   <= peak_n;
        o_result_count <= seen_n;
        o_codes_seen   <= codes_n;
    end

endmodule

// ----- dv/stack_calculator_core_tb.sv -----
// Testbench top for the stack calculator: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 100ps

module stack_calculator_core_tb;
    import stkc_pkg::*;

    localparam int DEPTH          = STACK_DEPTH_DEF;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [ACT_W-1:0]         i_action = '0;
    logic signed [DATA_W-1:0] i_push_value = '0;
    logic [IDX_W-1:0]         i_peek_index = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_result_value;
    logic [ERR_W-1:0]         o_error_code;
    logic [CNT_OUT_W-1:0]     o_entry_count;

    int         fail_count;
    int         pending;
    int         stack_level;
    int         peak_level;
    int         result_count;
    logic [5:0] codes_seen;
    int         words_sent = 0;
    int         steady_left = 0;
    int         idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    stack_calculator_core #(
        .STACK_DEPTH(DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_push_value   (i_push_value),
        .i_peek_index   (i_peek_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_error_code   (o_error_code),
        .o_entry_count  (o_entry_count)
    );

    stack_calculator_checker #(
        .STACK_DEPTH(DEPTH)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_push_value   (i_push_value),
        .i_peek_index   (i_peek_index),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_result_value (o_result_value),
        .i_error_code   (o_error_code),
        .i_entry_count  (o_entry_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_stack_level  (stack_level),
        .o_peak_level   (peak_level),
        .o_result_count (result_count),
        .o_codes_seen   (codes_seen)
    );

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return DATA_W'(int'($urandom_range(0, 16)) - 8);
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(input int depth_now);
        if (depth_now > 0 && $urandom_range(0, 3) != 0) begin
            return IDX_W'($urandom_range(0, depth_now - 1));
        end
        return IDX_W'($urandom());
    endfunction

    // Ends on the falling edge at which the next word is driven.
    task automatic pause_sender();
        int unsigned gap, roll;
        roll = $urandom_range(0, 99);
        if (steady_left > 0) begin
            steady_left--;
            gap = 0;
        end else if (roll < 4) begin
            steady_left = $urandom_range(20, 80);
            gap = 0;
        end else if (roll < 55) begin
            gap = 0;
        end else if (roll < 92) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 40);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic offer(input t_action act, input logic [DATA_W-1:0] val,
                         input logic [IDX_W-1:0] idx);
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_push_value <= val;
        i_peek_index <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic directed(input t_action act, input logic [DATA_W-1:0] val,
                            input logic [IDX_W-1:0] idx);
        pause_sender();
        offer(act, val, idx);
    endtask

    task automatic send_random(input logic draining);
        int unsigned push_pct;
        t_action     act;
        pause_sender();
        if (draining) begin
            push_pct = 10;
        end else if (stack_level < 4) begin
            push_pct = 60;
        end else if (stack_level > 48) begin
            push_pct = 15;
        end else begin
            push_pct = 40;
        end
        if ($urandom_range(0, 99) < push_pct) begin
            act = ACT_PUSH;
        end else begin
            act = t_action'($urandom_range(1, 7));
        end
        offer(act, pick_value(), pick_index(stack_level));
    endtask

    initial begin : result_sink
        int unsigned chunk, span, roll;
        logic        hold;
        chunk = 0;
        forever begin
            chunk++;
            roll = $urandom_range(0, 99);
            if (chunk == 60 || chunk == 400) begin
                hold = 1'b1;
                span = LONG_HOLD;
            end else if (roll < 20) begin
                hold = 1'b0;
                span = $urandom_range(40, 150);
            end else if (roll < 70) begin
                hold = 1'b0;
                span = $urandom_range(1, 4);
            end else if (roll < 95) begin
                hold = 1'b1;
                span = $urandom_range(1, 3);
            end else begin
                hold = 1'b1;
                span = $urandom_range(20, 60);
            end
            @(negedge i_clk);
            i_out_stall <= hold;
            repeat (span - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL stack_calculator_core");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Edge cases on an empty and a nearly empty stack, then wrapping and floor division.
        directed(ACT_POP, '0, '0);
        directed(ACT_PEEK_TOP, '0, '0);
        directed(ACT_PEEK_BOTTOM, '0, 10'h3FF);
        directed(ACT_ADD, '0, '0);
        directed(ACT_PUSH, 32'h7FFF_FFFF, '0);
        directed(ACT_MUL, '0, '0);
        directed(ACT_PUSH, 32'h8000_0000, 10'h3FF);
        directed(ACT_PEEK_TOP, '0, 10'd1);
        directed(ACT_PEEK_BOTTOM, '0, 10'd1);
        directed(ACT_PEEK_TOP, '0, 10'd2);
        directed(ACT_ADD, '0, '0);
        directed(ACT_PUSH, 32'h8000_0000, '0);
        directed(ACT_PUSH, 32'hFFFF_FFFF, '0);
        directed(ACT_DIV, '0, '0);
        directed(ACT_SUB, '0, '0);
        directed(ACT_PUSH, -7, '0);
        directed(ACT_PUSH, 32'd2, '0);
        directed(ACT_DIV, '0, '0);
        directed(ACT_MUL, '0, '0);
        directed(ACT_PUSH, '0, '0);
        directed(ACT_DIV, '0, '0);
        directed(ACT_POP, '0, '0);
        directed(ACT_PUSH, 32'd5, '0);
        directed(ACT_PUSH, -3, '0);
        directed(ACT_DIV, '0, '0);

        repeat (100) send_random(1'b0);

        while (stack_level < DEPTH) begin
            pause_sender();
            offer(ACT_PUSH, pick_value(), pick_index(stack_level));
        end
        directed(ACT_PUSH, pick_value(), '0);
        directed(ACT_PEEK_TOP, '0, 10'h3FF);
        directed(ACT_PEEK_BOTTOM, '0, 10'h3FF);
        directed(ACT_PUSH, pick_value(), '0);

        repeat (60) send_random(1'b1);
        repeat (100) send_random(1'b0);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words: directed edge cases, random mixes and a fill to %0d of %0d entries.",
                 words_sent, peak_level, DEPTH);
        $display("Checked %0d result words; error codes returned (code 0 rightmost): %b",
                 result_count, codes_seen);
        if (fail_count == 0) begin
            $display("PASS stack_calculator_core");
        end else begin
            $display("FAIL stack_calculator_core");
        end
        $finish;
    end

endmodule
